>>> rtl/tli_pkg.sv
// Shared types and constants for the table linear interpolation block.
`timescale 1ns / 1ps
package tli_pkg;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned CNT_W = 9;
	localparam int unsigned SLOT_W = 8;
	localparam int unsigned Q_W = 48;
	localparam int unsigned TABLE_DEPTH = 256;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	localparam logic [0:0] REG_POINTS_IN_USE = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_RD0,
		ST_CHK0,
		ST_RD1,
		ST_CHK1,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_OUT
	} back_state_t;

	typedef struct packed {
		logic [DATA_W-1:0] x_value;
		logic [DATA_W-1:0] y_value;
		logic [SLOT_W-1:0] entry_index;
		logic              cmd;
	} req_t;
endpackage

>>> rtl/tli_ram.sv
// Generic RAM with one write port, one read port and registered read.
`timescale 1ns / 1ps
module tli_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

>>> rtl/tli_front.sv
// Input side: request queue between the push port and the worker.
`timescale 1ns / 1ps
module tli_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tli_pkg::req_t  req_in,
	output logic           req_valid,
	input  logic           req_take,
	output tli_pkg::req_t  req_out
);
	import tli_pkg::*;

	localparam int unsigned DEPTH = 4;
	localparam int unsigned AW = 2;

	req_t            buf_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [AW:0]     cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full = (cnt_q == (AW+1)'(DEPTH));
	assign req_valid = (cnt_q != '0);
	assign req_out = buf_q[rd_q];
	assign do_push = push && !full;
	assign do_pop = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
		end
	end
endmodule

>>> rtl/tli_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tli_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [32:0]           num,
	input  logic [32:0]           den,
	output logic                  done,
	output logic [tli_pkg::Q_W:0] quo
);
	import tli_pkg::*;

	localparam int unsigned NB = Q_W + 1;

	logic [NB-1:0] dvd_q;
	logic [33:0]   rem_q;
	logic [32:0]   den_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic [33:0]   trial;
	logic [34:0]   diff;

	assign trial = {rem_q[32:0], dvd_q[NB-1]};
	assign diff = {1'b0, trial} - {2'b0, den_q};
	assign quo = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, 16'b0};
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!diff[34]) begin
				rem_q <= diff[33:0];
				dvd_q <= {dvd_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				dvd_q <= {dvd_q[NB-2:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/tli_back.sv
// Worker: table store, binary search, slope division and interpolation.
`timescale 1ns / 1ps
module tli_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_take,
	input  tli_pkg::req_t               req,
	input  logic [tli_pkg::CNT_W-1:0]   points_in_use,
	output logic                        empty,
	input  logic                        pop,
	output logic [tli_pkg::DATA_W-1:0]  y_result,
	output logic                        saturated
);
	import tli_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned IW = AW + 1;

	back_state_t state_q, state_d;

	logic [IW-1:0]      n_q;
	logic [IW-1:0]      lo_q, hi_q, mid;
	logic [IW-1:0]      i0_q, i1_q;
	logic signed [31:0] xq_q, x0_q, y0_q, x1_q, y1_q;
	logic [AW-1:0]      raddr;
	logic [31:0]        xr, yr;
	logic               we;
	logic [47:0]        q_q;
	logic [32:0]        b_q;
	logic               neg_q;
	logic [63:0]        plo_q, phi_q;
	logic [31:0]        res_q;
	logic               sat_q;
	logic [31:0]        out_y_q;
	logic               out_sat_q;
	logic               out_v_q;
	logic [IW-1:0]      n_eff;
	logic signed [32:0] dy, dx, dq, dy_rd, dx_rd;
	logic [32:0]        mdy, mdx;
	logic               div_start, div_done;
	logic [Q_W:0]       div_quo;
	logic [48:0]        t;
	logic signed [50:0] sum;

	assign we = req_valid && (state_q == ST_IDLE) && (req.cmd == CMD_LOAD)
		&& ({1'b0, req.entry_index} < 9'(TABLE_DEPTH));
	assign mid = IW'((lo_q + hi_q) >> 1);

	always_comb begin
		raddr = mid[AW-1:0];
		if (state_q == ST_RD0) raddr = i0_q[AW-1:0];
		if (state_q == ST_RD1) raddr = i1_q[AW-1:0];
	end

	tli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_xram (
		.clk(clk), .we(we), .waddr(req.entry_index[AW-1:0]), .wdata(req.x_value),
		.raddr(raddr), .rdata(xr));
	tli_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_yram (
		.clk(clk), .we(we), .waddr(req.entry_index[AW-1:0]), .wdata(req.y_value),
		.raddr(raddr), .rdata(yr));

	always_comb begin
		if (points_in_use == '0) n_eff = IW'(1);
		else if ({1'b0, points_in_use} > 10'(TABLE_DEPTH)) n_eff = IW'(TABLE_DEPTH);
		else n_eff = IW'(points_in_use);
	end

	assign dy = {y1_q[31], y1_q} - {y0_q[31], y0_q};
	assign dx = {x1_q[31], x1_q} - {x0_q[31], x0_q};
	assign dq = {xq_q[31], xq_q} - {x0_q[31], x0_q};
	// divider operands come straight from the second point's read data
	assign dy_rd = {yr[31], yr} - {y0_q[31], y0_q};
	assign dx_rd = {xr[31], xr} - {x0_q[31], x0_q};
	assign mdy = dy_rd[32] ? 33'(-dy_rd) : 33'(dy_rd);
	assign mdx = dx_rd[32] ? 33'(-dx_rd) : 33'(dx_rd);
	assign div_start = (state_q == ST_CHK1) && (xr != x0_q);

	tli_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(mdy), .den(mdx),
		.done(div_done), .quo(div_quo));

	// product q*b split into the low 32 bits and high 16 bits of q
	assign t = (phi_q < 64'h1_0000_0000) ? 49'((phi_q << 16) + (plo_q >> 16))
		: 49'h1_0000_0000_0000;
	assign sum = neg_q ? 51'(y0_q) - 51'(t) : 51'(y0_q) + 51'(t);

	assign empty = !out_v_q;
	assign y_result = out_y_q;
	assign saturated = out_sat_q;
	assign req_take = (state_q == ST_IDLE) && req_valid;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req_valid && req.cmd == CMD_QUERY) state_d = ST_SRCH_RD;
			ST_SRCH_RD: state_d = (hi_q > lo_q + 1'b1) ? ST_SRCH_CMP : ST_RD0;
			ST_SRCH_CMP: state_d = ($signed(xr) == xq_q) ? ST_RD0 : ST_SRCH_RD;
			ST_RD0: state_d = ST_CHK0;
			ST_CHK0: begin
				if ($signed(xr) == xq_q) state_d = ST_OUT;
				else if (i0_q + 1'b1 == n_q && i0_q == '0) state_d = ST_OUT;
				else state_d = ST_RD1;
			end
			ST_RD1: state_d = ST_CHK1;
			ST_CHK1: state_d = ($signed(xr) == x0_q) ? ST_OUT : ST_DIV;
			ST_DIV: if (div_done) state_d = ST_MUL;
			ST_MUL: state_d = ST_SUM;
			ST_SUM: state_d = ST_OUT;
			ST_OUT: if (!out_v_q) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && out_v_q) out_v_q <= 1'b0;
			if (state_q == ST_OUT && !out_v_q) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				xq_q <= req.x_value;
				n_q <= n_eff;
				lo_q <= '0;
				hi_q <= n_eff;
				sat_q <= 1'b0;
			end
			ST_SRCH_RD: i0_q <= lo_q;
			ST_SRCH_CMP: begin
				if ($signed(xr) == xq_q) i0_q <= mid;
				else if ($signed(xr) > xq_q) hi_q <= mid;
				else lo_q <= mid;
			end
			ST_CHK0: begin
				x0_q <= xr;
				y0_q <= yr;
				res_q <= yr;
				i1_q <= (i0_q + 1'b1 == n_q) ? i0_q - 1'b1 : i0_q + 1'b1;
			end
			ST_CHK1: begin
				x1_q <= xr;
				y1_q <= yr;
			end
			ST_DIV: begin
				q_q <= div_quo[47:0];
				b_q <= dq[32] ? 33'(-dq) : 33'(dq);
				neg_q <= (dy[32] != dx[32]) ^ dq[32];
			end
			ST_MUL: begin
				plo_q <= 64'(q_q[31:0]) * 64'(b_q);
				phi_q <= 64'(q_q[47:32]) * 64'(b_q);
			end
			ST_SUM: begin
				if (sum > 51'sh7FFF_FFFF) begin
					res_q <= 32'h7FFF_FFFF;
					sat_q <= 1'b1;
				end else if (sum < -51'sh8000_0000) begin
					res_q <= 32'h8000_0000;
					sat_q <= 1'b1;
				end else begin
					res_q <= sum[31:0];
				end
			end
			default: ;
		endcase
		// hold the waiting result apart from the working registers
		if (state_q == ST_OUT && !out_v_q) begin
			out_y_q <= res_q;
			out_sat_q <= sat_q;
		end
	end
endmodule

>>> rtl/table_linear_interpolation_top.sv
// Top level: APB register, request queue and interpolation worker.
`timescale 1ns / 1ps
// Piecewise linear lookup over a table of up to TABLE_DEPTH (x, y) points.
// Push side: push/full with cmd, entry_index, x_value, y_value. A load
// (cmd 0) writes one point and gives no result. A query
// (cmd 1) gives one result y_result/saturated on the empty/pop side.
// A four-entry request queue decouples the push side from the worker.
// A query uses the bit-serial slope divider when it interpolates;
// matches and single-point tables skip the divider. One query is
// worked at a time, set by the shared table read port and the divider.
// The APB register points_in_use (address 0) picks the active points;
// write it only while idle. Reset clears the queue and the result stage
// and sets points_in_use to 1; the table contents are undefined until
// loaded. While pop is low the result holds and the worker waits after
// finishing its next result, so the queue fills and full rises.
module table_linear_interpolation_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [1:0]                 paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       push,
	output logic                       full,
	input  logic                       cmd,
	input  logic [tli_pkg::SLOT_W-1:0] entry_index,
	input  logic signed [31:0]         x_value,
	input  logic signed [31:0]         y_value,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [31:0]         y_result,
	output logic                       saturated
);
	import tli_pkg::*;

	logic [CNT_W-1:0] piu_q;
	req_t             req_in, req_q;
	logic             req_valid, req_take;

	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == {REG_POINTS_IN_USE, 1'b0}) ? 32'(piu_q) : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			piu_q <= CNT_W'(1);
		end else if (psel && penable && pwrite && paddr[1:0] == {REG_POINTS_IN_USE, 1'b0}) begin
			piu_q <= pwdata[CNT_W-1:0];
		end
	end

	assign req_in = '{x_value: x_value, y_value: y_value,
		entry_index: entry_index, cmd: cmd};

	tli_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req_in(req_in),
		.req_valid(req_valid), .req_take(req_take), .req_out(req_q));

	tli_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_take(req_take),
		.req(req_q), .points_in_use(piu_q), .empty(empty), .pop(pop),
		.y_result(y_result), .saturated(saturated));
endmodule

>>> dv/testbench.sv
// Testbench for the table linear interpolation block: predictor, stimulus and result checks.
`timescale 1ns / 1ps
module testbench;
	import tli_pkg::*;

	typedef enum int {K_LOAD, K_QUERY, K_CFG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [7:0]  slot;
		logic [31:0] xv;
		logic [31:0] yv;
		bit          typed;
		logic [31:0] y_exp;
		logic        sat_exp;
	} stim_row_t;

	typedef struct {
		logic [31:0] y;
		logic        sat;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                push = 1'b0;
	logic                full;
	logic                cmd = 1'b0;
	logic [SLOT_W-1:0]   entry_index = '0;
	logic signed [31:0]  x_value = '0, y_value = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic signed [31:0]  y_result;
	logic                saturated;

	logic signed [31:0]  pt_x [256];
	logic signed [31:0]  pt_y [256];
	logic [8:0]          active_pts = 9'd1;
	answer_t             pending_answers[$];
	int                  errors = 0;
	int                  n_loads = 0, n_queries = 0, n_results = 0, n_sat = 0;
	bit                  steady = 1'b0;

	table_linear_interpolation_top u_dut (.*);

	always #2 clk = ~clk;

	function automatic bit [63:0] magnitude(input longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic answer_t interpolate(input logic signed [31:0] xq);
		answer_t      a;
		int           n, lo, hi, mid, i0, i1;
		longint       x, x0, y0, x1, y1, dy, dx, dq, sum;
		bit [63:0]    q, b, ah, al, plo, phi, t;
		bit           neg;
		n = active_pts == 0 ? 1 : (active_pts > 256 ? 256 : active_pts);
		x = xq;
		lo = 0;
		hi = n;
		while (hi > lo + 1) begin
			mid = (lo + hi) / 2;
			if (pt_x[mid] == xq) begin
				lo = mid;
				break;
			end else if (pt_x[mid] > xq) begin
				hi = mid;
			end else begin
				lo = mid;
			end
		end
		i0 = lo;
		x0 = pt_x[i0];
		y0 = pt_y[i0];
		a.y = pt_y[i0];
		a.sat = 1'b0;
		if (x == x0) return a;
		i1 = i0 + 1;
		if (i1 == n) begin
			if (i0 == 0) return a;
			i1 = i0 - 1;
		end
		x1 = pt_x[i1];
		y1 = pt_y[i1];
		if (x1 == x0) return a;
		dy = y1 - y0;
		dx = x1 - x0;
		q = (magnitude(dy) << 16) / magnitude(dx);
		neg = (dy < 0) != (dx < 0);
		dq = x - x0;
		b = magnitude(dq);
		if (dq < 0) neg = !neg;
		// partial products wrap at 64 bits, as the fixed-point definition does
		ah = q >> 32;
		al = q & 64'hFFFF_FFFF;
		plo = al * b;
		phi = ah * b;
		t = (phi < 64'h1_0000_0000) ? (phi << 16) + (plo >> 16) : 64'h1 << 48;
		sum = neg ? y0 - longint'(t) : y0 + longint'(t);
		if (sum > 64'sd2147483647) begin
			a.y = 32'h7FFF_FFFF;
			a.sat = 1'b1;
		end else if (sum < -64'sd2147483648) begin
			a.y = 32'h8000_0000;
			a.sat = 1'b1;
		end else begin
			a.y = sum[31:0];
		end
		return a;
	endfunction

	// Drive one request and wait for the request queue to accept it; then maybe idle.
	task automatic send_request(input cmd_t c, input logic [7:0] slot, input logic [31:0] xv,
			input logic [31:0] yv, input bit typed, input answer_t given);
		int gap;
		push <= 1'b1;
		cmd <= c;
		entry_index <= slot;
		x_value <= xv;
		y_value <= yv;
		do @(posedge clk); while (full);
		if (c == CMD_LOAD) begin
			pt_x[slot] = xv;
			pt_y[slot] = yv;
			n_loads++;
		end else begin
			pending_answers.push_back(typed ? given : interpolate(xv));
			n_queries++;
		end
		if (!steady && $urandom_range(99) < 29) begin
			gap = $urandom_range(1, 6);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0) @(posedge clk);
		// a trailing load may still sit in the queue; wait out a full query time
		repeat (200) @(posedge clk);
	endtask

	task automatic write_points(input logic [8:0] value);
		drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 2'(4 * REG_POINTS_IN_USE);
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		active_pts = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[8:0] !== value) begin
			$display("%0t: points_in_use readback expected %0d actual %0d",
				$time, value, prdata[8:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_table(input int n, input int mode);
		longint xc, step;
		answer_t none;
		none = '{default: '0};
		xc = (mode == 0) ? -64'sd2147483648 + $urandom_range(0, 32'h3FFF_FFFF)
			: longint'($signed($urandom_range(32'hFFFF_FFFF, 0))) / 2;
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: step = $urandom_range(1, 32'h007F_FFFF);
				1: step = $urandom_range(1, 3);
				2: step = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 32'h0003_0000);
				default: step = 0;
			endcase
			xc = xc + step;
			if (xc > 64'sd2147483647) xc = 64'sd2147483647;
			send_request(CMD_LOAD, 8'(i), (mode == 3) ? $urandom() : xc[31:0],
				$urandom(), 1'b0, none);
		end
	endtask

	function automatic logic [31:0] pick_query(input int n);
		int k, r;
		k = $urandom_range(n - 1);
		r = $urandom_range(9);
		case (r)
			0, 1: return pt_x[k];
			2: return pt_x[k] + 1;
			3: return pt_x[k] - 1;
			4, 5: return 32'((longint'(pt_x[k]) + longint'(pt_x[(k + 1) % n])) / 2);
			6, 7: return $urandom();
			8: return 32'h8000_0000;
			default: return 32'h7FFF_FFFF;
		endcase
	endfunction

	// result side: check the head, then pick the next pop
	initial begin
		answer_t want;
		forever begin
			@(posedge clk);
			if (arst_n && pop && !empty) begin
				n_results++;
				if (saturated === 1'b1) n_sat++;
				if (pending_answers.size() == 0) begin
					$display("%0t: result %h/%b with no query outstanding",
						$time, y_result, saturated);
					errors++;
				end else begin
					want = pending_answers.pop_front();
					if (y_result !== want.y) begin
						$display("%0t: y_result expected %h actual %h", $time, want.y, y_result);
						errors++;
					end
					if (saturated !== want.sat) begin
						$display("%0t: saturated expected %b actual %b",
							$time, want.sat, saturated);
						errors++;
					end
				end
			end
			pop <= arst_n && (steady || $urandom_range(99) >= 29);
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		stim_row_t rows[$];
		answer_t   given;
		int        phase_n[7];
		int        phase_mode[7];
		int        n;
		phase_n = '{2, 32, 1, 3, 256, 17, 16};
		phase_mode = '{1, 0, 0, 3, 2, 1, 0};
		rows = '{
			'{K_CFG,   8'd0, 32'd1,          32'd0,          0, 0, 0},
			'{K_LOAD,  8'd0, 32'h0000_0000,  32'h0005_0000,  0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0000_0000,  32'd0,          1, 32'h0005_0000, 0},
			'{K_QUERY, 8'd0, 32'h8000_0000,  32'd0,          1, 32'h0005_0000, 0},
			'{K_QUERY, 8'd0, 32'h7FFF_FFFF,  32'd0,          1, 32'h0005_0000, 0},
			'{K_CFG,   8'd0, 32'd2,          32'd0,          0, 0, 0},
			'{K_LOAD,  8'd0, 32'h0000_0000,  32'h8000_0000,  0, 0, 0},
			'{K_LOAD,  8'd1, 32'h0000_0001,  32'h7FFF_FFFF,  0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0000_0000,  32'd0,          1, 32'h8000_0000, 0},
			'{K_QUERY, 8'd0, 32'h0000_0001,  32'd0,          1, 32'h7FFF_FFFF, 0},
			'{K_QUERY, 8'd0, 32'h7FFF_FFFF,  32'd0,          1, 32'h7FFF_FFFF, 1},
			'{K_QUERY, 8'd0, 32'h8000_0000,  32'd0,          1, 32'h8000_0000, 1},
			'{K_LOAD,  8'd1, 32'h0000_0000,  32'h0000_0003,  0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0000_0005,  32'd0,          1, 32'h0000_0003, 0},
			'{K_LOAD,  8'd0, 32'h0000_0000,  32'h0000_0000,  0, 0, 0},
			'{K_LOAD,  8'd1, 32'h0002_0000,  32'h0004_0000,  0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0001_0000,  32'd0,          0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0003_0000,  32'd0,          0, 0, 0},
			'{K_QUERY, 8'd0, 32'hFFFF_0000,  32'd0,          0, 0, 0},
			'{K_CFG,   8'd0, 32'd3,          32'd0,          0, 0, 0},
			'{K_LOAD,  8'd2, 32'h0003_0000,  32'hFFFF_8000,  0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0002_8000,  32'd0,          0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0000_8000,  32'd0,          0, 0, 0},
			'{K_QUERY, 8'd0, 32'h0100_0000,  32'd0,          0, 0, 0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			given.y = rows[i].y_exp;
			given.sat = rows[i].sat_exp;
			case (rows[i].kind)
				K_CFG: write_points(rows[i].xv[8:0]);
				K_LOAD: send_request(CMD_LOAD, rows[i].slot, rows[i].xv, rows[i].yv, 0, given);
				default: send_request(CMD_QUERY, 8'hFF, rows[i].xv, $urandom(),
					rows[i].typed, given);
			endcase
		end
		foreach (phase_n[p]) begin
			n = phase_n[p];
			steady = (p == 3);
			write_points(9'(n));
			load_table(n, phase_mode[p]);
			for (int j = 0; j < 36; j++) begin
				// rewrite an active point now and then; it stays written
				if ($urandom_range(19) == 0)
					send_request(CMD_LOAD, 8'($urandom_range(n - 1)), $urandom(), $urandom(),
						0, given);
				send_request(CMD_QUERY, 8'($urandom()), pick_query(n), $urandom(), 0, given);
			end
		end
		steady = 1'b0;
		drain();
		$display("covered %0d loads and %0d queries over point counts 1 to 256", n_loads, n_queries);
		$display("checked %0d results, %0d of them clipped", n_results, n_sat);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
